// ===== design/hmtp_pkg.sv =====
// ----------------------------------------------------------------------------
// hmtp_pkg
// shared types and constants of the text height map parser
// ----------------------------------------------------------------------------
package hmtp_pkg;

    typedef enum logic [6:0] {
        PH_BETWEEN = 7'b0000001,
        PH_NUMBER  = 7'b0000010,
        PH_COMMA   = 7'b0000100,
        PH_ZERO    = 7'b0001000,
        PH_HEX     = 7'b0010000,
        PH_TRAIL   = 7'b0100000,
        PH_DONE    = 7'b1000000
    } t_phase;

    typedef logic [7:0] t_color [4];

    typedef struct packed {
        logic signed [31:0] height;
        logic [7:0]         red;
        logic [7:0]         green;
        logic [7:0]         blue;
        logic [7:0]         alpha;
        logic               malformed;
        logic               last_cell;
    } t_cell;

    localparam logic [7:0] DEF_RED   = 8'd255;
    localparam logic [7:0] DEF_GREEN = 8'd140;
    localparam logic [7:0] DEF_BLUE  = 8'd0;
    localparam logic [7:0] DEF_ALPHA = 8'd255;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0d;
    localparam logic [7:0] CH_COMMA = 8'h2c;
    localparam logic [7:0] CH_MINUS = 8'h2d;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_X     = 8'h78;
    localparam logic [7:0] CH_LO_A  = 8'h61;
    localparam logic [7:0] CH_LO_F  = 8'h66;
    localparam logic [7:0] CH_UP_A  = 8'h41;
    localparam logic [7:0] CH_UP_F  = 8'h46;

    localparam logic [31:0] SAT_MAG = 32'h8000_0000;
    localparam logic [31:0] POS_MAX = 32'h7fff_ffff;

    localparam logic [2:0] NUM_CHANNELS = 3'd4;

endpackage

// ===== design/hmtp_cfg.sv =====
// ----------------------------------------------------------------------------
// hmtp_cfg
// apb register port holding the expected cell count
// ----------------------------------------------------------------------------
module hmtp_cfg #(
    parameter int COUNT_BITS = 24
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [2:0]            paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready,
    output logic [COUNT_BITS-1:0] o_cell_count
);

    logic [COUNT_BITS-1:0] r_cell_count;
    logic                  wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && !paddr[2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cell_count <= COUNT_BITS'(1);
        end else if (wr_en) begin
            r_cell_count <= pwdata[COUNT_BITS-1:0];
        end
    end

    assign prdata       = paddr[2] ? 32'd0 : 32'(r_cell_count);
    assign o_cell_count = r_cell_count;

endmodule

// ===== design/hmtp_core.sv =====
// ----------------------------------------------------------------------------
// hmtp_core
// per-byte parser state and the combinational step that closes cells
// ----------------------------------------------------------------------------
module hmtp_core #(
    parameter int MAX_NUMBER_CHARS = 11,
    parameter int COUNT_BITS       = 24
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_step,
    input  logic [7:0]            i_text_byte,
    input  logic                  i_end_of_text,
    input  logic [COUNT_BITS-1:0] i_cell_count,
    output logic                  o_emit,
    output hmtp_pkg::t_cell       o_cell
);

    localparam int CHARS_W = $clog2(MAX_NUMBER_CHARS + 1);
    localparam logic [CHARS_W-1:0] CHARS_MAX = CHARS_W'(MAX_NUMBER_CHARS);

    hmtp_pkg::t_phase      r_phase,  f_phase,  n_phase;
    logic                  r_neg,    f_neg,    n_neg;
    logic [31:0]           r_acc,    f_acc,    n_acc;
    logic [CHARS_W-1:0]    r_chars,  f_chars,  n_chars;
    logic [2:0]            r_chan,   f_chan,   n_chan;
    logic [4:0]            r_nib,    f_nib,    n_nib;
    hmtp_pkg::t_color      r_color,  f_color,  n_color;
    logic                  r_err,    f_err,    n_err;
    logic [COUNT_BITS-1:0] r_done,   n_done;

    logic                  is_ws, is_dig, is_hex, go, close;
    logic [3:0]            hex_val;
    logic [34:0]           acc_mul;
    logic [31:0]           mag;
    logic [COUNT_BITS:0]   target, done_inc;
    logic                  reached, emit_err;

    // character classes
    always_comb begin
        is_ws  = (i_text_byte == hmtp_pkg::CH_SPACE) ||
                 (i_text_byte >= hmtp_pkg::CH_TAB && i_text_byte <= hmtp_pkg::CH_CR);
        is_dig = i_text_byte >= hmtp_pkg::CH_ZERO && i_text_byte <= hmtp_pkg::CH_NINE;
        is_hex = 1'b1;
        hex_val = 4'd0;
        if (is_dig) begin
            hex_val = 4'(i_text_byte - hmtp_pkg::CH_ZERO);
        end else if (i_text_byte >= hmtp_pkg::CH_LO_A && i_text_byte <= hmtp_pkg::CH_LO_F) begin
            hex_val = 4'(i_text_byte - hmtp_pkg::CH_LO_A + 8'd10);
        end else if (i_text_byte >= hmtp_pkg::CH_UP_A && i_text_byte <= hmtp_pkg::CH_UP_F) begin
            hex_val = 4'(i_text_byte - hmtp_pkg::CH_UP_A + 8'd10);
        end else begin
            is_hex = 1'b0;
        end
        acc_mul = {r_acc, 3'b000} + {2'b00, r_acc, 1'b0} + 35'(hex_val);
    end

    // byte feed
    always_comb begin
        f_phase = r_phase;
        f_neg   = r_neg;
        f_acc   = r_acc;
        f_chars = r_chars;
        f_chan  = r_chan;
        f_nib   = r_nib;
        f_color = r_color;
        f_err   = r_err;
        close   = 1'b0;
        go      = 1'b0;
        unique case (r_phase)
            hmtp_pkg::PH_DONE: go = 1'b0;
            hmtp_pkg::PH_BETWEEN: begin
                if (is_ws) begin
                    go = 1'b0;
                end else if (i_text_byte == hmtp_pkg::CH_COMMA) begin
                    f_phase = hmtp_pkg::PH_COMMA;
                end else if (is_dig || i_text_byte == hmtp_pkg::CH_MINUS) begin
                    f_phase = hmtp_pkg::PH_NUMBER;
                    go      = 1'b1;
                end else begin
                    f_err   = 1'b1;
                    f_phase = hmtp_pkg::PH_TRAIL;
                end
            end
            default: go = 1'b1;
        endcase

        if (go) begin
            if (is_ws) begin
                close = 1'b1;
            end else begin
                unique case (f_phase)
                    hmtp_pkg::PH_NUMBER: begin
                        if (is_dig) begin
                            if (r_chars < CHARS_MAX) begin
                                f_chars = r_chars + CHARS_W'(1);
                                if (r_acc < hmtp_pkg::SAT_MAG) begin
                                    f_acc = (acc_mul > 35'(hmtp_pkg::SAT_MAG)) ?
                                            hmtp_pkg::SAT_MAG : acc_mul[31:0];
                                end
                            end
                        end else if (i_text_byte == hmtp_pkg::CH_MINUS) begin
                            if (r_chars == '0) begin
                                f_neg   = 1'b1;
                                f_chars = CHARS_W'(1);
                            end else begin
                                f_err   = 1'b1;
                                f_chars = CHARS_MAX;
                            end
                        end else if (i_text_byte == hmtp_pkg::CH_COMMA) begin
                            f_phase = hmtp_pkg::PH_COMMA;
                        end else begin
                            f_err   = 1'b1;
                            f_phase = hmtp_pkg::PH_TRAIL;
                        end
                    end
                    hmtp_pkg::PH_COMMA: begin
                        if (i_text_byte == hmtp_pkg::CH_ZERO) begin
                            f_phase = hmtp_pkg::PH_ZERO;
                        end else begin
                            f_err   = 1'b1;
                            f_phase = hmtp_pkg::PH_TRAIL;
                        end
                    end
                    hmtp_pkg::PH_ZERO: begin
                        if (i_text_byte == hmtp_pkg::CH_X) begin
                            f_phase = hmtp_pkg::PH_HEX;
                        end else begin
                            f_err   = 1'b1;
                            f_phase = hmtp_pkg::PH_TRAIL;
                        end
                    end
                    hmtp_pkg::PH_HEX: begin
                        if (is_hex) begin
                            if (r_chan >= hmtp_pkg::NUM_CHANNELS) begin
                                f_err = 1'b1;
                            end else if (r_nib[4]) begin
                                f_color[r_chan[1:0]] = {r_nib[3:0], hex_val};
                                f_chan = r_chan + 3'd1;
                                f_nib  = 5'd0;
                            end else begin
                                f_nib = {1'b1, hex_val};
                            end
                        end else begin
                            f_err   = 1'b1;
                            f_phase = hmtp_pkg::PH_TRAIL;
                        end
                    end
                    default: close = 1'b0;
                endcase
            end
        end
    end

    // cell close and end of text
    always_comb begin
        o_emit = close || (i_end_of_text && f_phase != hmtp_pkg::PH_BETWEEN &&
                           f_phase != hmtp_pkg::PH_DONE);
        emit_err = f_err || f_phase == hmtp_pkg::PH_COMMA || f_phase == hmtp_pkg::PH_ZERO ||
                   (f_phase == hmtp_pkg::PH_HEX && f_nib[4]);
        mag      = (f_acc > hmtp_pkg::SAT_MAG) ? hmtp_pkg::SAT_MAG : f_acc;
        target   = (i_cell_count == '0) ? {1'b1, {COUNT_BITS{1'b0}}} : {1'b0, i_cell_count};
        done_inc = {1'b0, r_done} + (COUNT_BITS+1)'(1);
        reached  = done_inc >= target;

        o_cell.height    = f_neg ? (32'd0 - mag) :
                           ((mag > hmtp_pkg::POS_MAX) ? hmtp_pkg::POS_MAX : mag);
        o_cell.red       = f_color[0];
        o_cell.green     = f_color[1];
        o_cell.blue      = f_color[2];
        o_cell.alpha     = f_color[3];
        o_cell.malformed = emit_err;
        o_cell.last_cell = i_end_of_text || reached;

        n_phase = f_phase;
        n_neg   = f_neg;
        n_acc   = f_acc;
        n_chars = f_chars;
        n_chan  = f_chan;
        n_nib   = f_nib;
        n_color = f_color;
        n_err   = f_err;
        n_done  = r_done;
        if (o_emit || i_end_of_text) begin
            n_neg   = 1'b0;
            n_acc   = 32'd0;
            n_chars = '0;
            n_chan  = 3'd0;
            n_nib   = 5'd0;
            n_color = '{hmtp_pkg::DEF_RED, hmtp_pkg::DEF_GREEN,
                        hmtp_pkg::DEF_BLUE, hmtp_pkg::DEF_ALPHA};
            n_err   = 1'b0;
        end
        if (o_emit) begin
            n_done  = done_inc[COUNT_BITS-1:0];
            n_phase = reached ? hmtp_pkg::PH_DONE : hmtp_pkg::PH_BETWEEN;
        end
        if (i_end_of_text) begin
            n_phase = hmtp_pkg::PH_BETWEEN;
            n_done  = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= hmtp_pkg::PH_BETWEEN;
            r_neg   <= 1'b0;
            r_acc   <= 32'd0;
            r_chars <= '0;
            r_chan  <= 3'd0;
            r_nib   <= 5'd0;
            r_color <= '{hmtp_pkg::DEF_RED, hmtp_pkg::DEF_GREEN,
                         hmtp_pkg::DEF_BLUE, hmtp_pkg::DEF_ALPHA};
            r_err   <= 1'b0;
            r_done  <= '0;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_neg   <= n_neg;
            r_acc   <= n_acc;
            r_chars <= n_chars;
            r_chan  <= n_chan;
            r_nib   <= n_nib;
            r_color <= n_color;
            r_err   <= n_err;
            r_done  <= n_done;
        end
    end

endmodule

// ===== design/height_map_text_parser.sv =====
// ----------------------------------------------------------------------------
// height_map_text_parser
// streaming parser of a whitespace separated height map with hex colors
// ----------------------------------------------------------------------------
// Takes one text byte per cycle while the output side is ready and gives
// one cell item per closed cell. A byte passes the input register and one
// parse step into the result register, so a cell item is registered from
// the byte that closes it; with the output side ready the block sustains one
// byte every cycle, set by the parse step that updates the cell state. The
// cell_count register sits at byte address 0; the user must write it only
// while the block is idle, and the block itself does not enforce this.
module height_map_text_parser #(
    parameter int MAX_NUMBER_CHARS = 11,
    parameter int COUNT_BITS       = 24
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [7:0]         i_text_byte,
    input  logic               i_end_of_text,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic signed [31:0] o_height,
    output logic [7:0]         o_red,
    output logic [7:0]         o_green,
    output logic [7:0]         o_blue,
    output logic [7:0]         o_alpha,
    output logic               o_malformed,
    output logic               o_last_cell
);

    logic [COUNT_BITS-1:0] cell_count;
    logic                  r_in_valid;
    logic [7:0]            r_text_byte;
    logic                  r_end;
    logic                  advance;
    logic                  emit;
    hmtp_pkg::t_cell       next_cell;
    logic                  r_out_valid;
    hmtp_pkg::t_cell       r_cell;

    hmtp_cfg #(
        .COUNT_BITS (COUNT_BITS)
    ) u_cfg (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .o_cell_count (cell_count)
    );

    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_text_byte <= i_text_byte;
            r_end       <= i_end_of_text;
        end
    end

    hmtp_core #(
        .MAX_NUMBER_CHARS (MAX_NUMBER_CHARS),
        .COUNT_BITS       (COUNT_BITS)
    ) u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_step        (advance),
        .i_text_byte   (r_text_byte),
        .i_end_of_text (r_end),
        .i_cell_count  (cell_count),
        .o_emit        (emit),
        .o_cell        (next_cell)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= emit;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && emit) begin
            r_cell <= next_cell;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_height    = r_cell.height;
    assign o_red       = r_cell.red;
    assign o_green     = r_cell.green;
    assign o_blue      = r_cell.blue;
    assign o_alpha     = r_cell.alpha;
    assign o_malformed = r_cell.malformed;
    assign o_last_cell = r_cell.last_cell;

endmodule
